FILE: hdl/cdu_pkg.sv
// Shared types and constants for the catalog record decimal unpacker.
package cdu_pkg;

    // Field widths
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned A_W       = 33;
    localparam int unsigned B_W       = 15;
    localparam int unsigned C_W       = 10;
    localparam int unsigned D_W       = 7;
    localparam int unsigned E_W       = 4;
    localparam int unsigned F_W       = 4;
    localparam int unsigned FLD_W     = 10;
    localparam int unsigned OBS_N     = 5;
    localparam int unsigned OBS_IDX_W = 3;
    localparam int unsigned TDATA_W   = 80;

    // Word positions inside one 20-word record
    localparam logic [POS_W-1:0] POS_RA        = 5'd0;
    localparam logic [POS_W-1:0] POS_SPD       = 5'd1;
    localparam logic [POS_W-1:0] POS_MOTION    = 5'd2;
    localparam logic [POS_W-1:0] POS_PHOT      = 5'd3;
    localparam logic [POS_W-1:0] POS_SIGMA     = 5'd4;
    localparam logic [POS_W-1:0] POS_OBS_FIRST = 5'd5;
    localparam logic [POS_W-1:0] POS_RES_FIRST = 5'd10;
    localparam logic [POS_W-1:0] POS_SCN_FIRST = 5'd15;
    localparam logic [POS_W-1:0] POS_LAST      = 5'd19;

    // Range limits and offsets
    localparam logic [WORD_W-1:0] RA_MAX     = 32'd129600000;
    localparam logic [WORD_W-1:0] SPD_MAX    = 32'd64800000;
    localparam logic [WORD_W-1:0] SCAN_MAX   = 32'd9999999;
    localparam logic [FLD_W-1:0]  FIELD_MAX  = 10'd937;
    localparam logic signed [A_W-1:0] DEC_OFFSET  = 33'sd32400000;
    localparam logic signed [A_W-1:0] PM_OFFSET_A = 33'sd5000;
    localparam logic signed [B_W-1:0] PM_OFFSET_B = 15'sd5000;

    // Reciprocals for floor(w / (2^k * odd)): (w >> k) * MAG >> S is exact
    // for every dividend width used here (S = dividend bits + ceil(log2 odd)).
    localparam int unsigned S_Q4 = 38;  // 10^4 = 16  * 625
    localparam int unsigned S_Q3 = 36;  // 10^3 = 8   * 125
    localparam int unsigned S_Q6 = 40;  // 10^6 = 64  * 15625
    localparam int unsigned S_Q7 = 42;  // 10^7 = 128 * 78125
    localparam int unsigned S_Q8 = 43;  // 10^8 = 256 * 390625
    localparam int unsigned S_Q9 = 44;  // 10^9 = 512 * 1953125
    localparam logic [63:0] MAG_Q4 = ((64'd1 << S_Q4) + 64'd624) / 64'd625;
    localparam logic [63:0] MAG_Q3 = ((64'd1 << S_Q3) + 64'd124) / 64'd125;
    localparam logic [63:0] MAG_Q6 = ((64'd1 << S_Q6) + 64'd15624) / 64'd15625;
    localparam logic [63:0] MAG_Q7 = ((64'd1 << S_Q7) + 64'd78124) / 64'd78125;
    localparam logic [63:0] MAG_Q8 = ((64'd1 << S_Q8) + 64'd390624) / 64'd390625;
    localparam logic [63:0] MAG_Q9 = ((64'd1 << S_Q9) + 64'd1953124) / 64'd1953125;

    // Word plus its decimal quotients
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic [18:0]       q4;   // word / 10^4
        logic [22:0]       q3;   // word / 10^3
        logic [12:0]       q6;   // word / 10^6
        logic [8:0]        q7;   // word / 10^7
        logic [5:0]        q8;   // word / 10^8
        logic [2:0]        q9;   // word / 10^9
    } cdu_quot_t;

    // One unpacked result word
    typedef struct packed {
        logic [POS_W-1:0]     pos;
        logic signed [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        logic [C_W-1:0]       c;
        logic [D_W-1:0]       d;
        logic [E_W-1:0]       e;
        logic [F_W-1:0]       f;
        logic                 err;
        logic                 last;
    } cdu_result_t;

endpackage

FILE: hdl/cdu_divide.sv
// Quotient stage: divides the record word by powers of ten with reciprocal multiplies.
module cdu_divide
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [cdu_pkg::WORD_W-1:0]    word,
    input  logic [cdu_pkg::POS_W-1:0]     pos,
    output cdu_pkg::cdu_quot_t            quot_reg
);

    cdu_pkg::cdu_quot_t quot_next;
    logic [56:0] p4;
    logic [58:0] p3;
    logic [52:0] p6;
    logic [50:0] p7;
    logic [48:0] p8;
    logic [46:0] p9;

    // Shift out the power-of-two factor, then multiply by the odd reciprocal
    assign p4 = 57'(word[31:4]) * 57'(cdu_pkg::MAG_Q4[28:0]);
    assign p3 = 59'(word[31:3]) * 59'(cdu_pkg::MAG_Q3[29:0]);
    assign p6 = 53'(word[31:6]) * 53'(cdu_pkg::MAG_Q6[26:0]);
    assign p7 = 51'(word[31:7]) * 51'(cdu_pkg::MAG_Q7[25:0]);
    assign p8 = 49'(word[31:8]) * 49'(cdu_pkg::MAG_Q8[24:0]);
    assign p9 = 47'(word[31:9]) * 47'(cdu_pkg::MAG_Q9[23:0]);

    always_comb
    begin
        quot_next.word = word;
        quot_next.pos  = pos;
        quot_next.q4   = p4[56:38];
        quot_next.q3   = p3[58:36];
        quot_next.q6   = p6[52:40];
        quot_next.q7   = p7[50:42];
        quot_next.q8   = p8[48:43];
        quot_next.q9   = p9[46:44];
    end

    // Advance with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

endmodule

FILE: hdl/cdu_fields.sv
// Field stage: digit groups, offsets, range checks, record state and result register.
module cdu_fields
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 take,
    input  cdu_pkg::cdu_quot_t   quot,
    output cdu_pkg::cdu_result_t res_reg
);

    cdu_pkg::cdu_result_t res_next;
    logic [3:0]  det_reg;
    logic [3:0]  det_next;
    logic [cdu_pkg::FLD_W-1:0] fld_mem [cdu_pkg::OBS_N];
    logic [cdu_pkg::OBS_IDX_W-1:0] obs_idx;
    logic [cdu_pkg::FLD_W-1:0] fld_rd;
    logic        fld_we;

    logic [13:0] rem_w4;   // word mod 10^4
    logic [13:0] rem_q4;   // (word / 10^4) mod 10^4
    logic [9:0]  rem_w3;   // word mod 10^3
    logic [9:0]  rem_q3;   // (word / 10^3) mod 10^3
    logic [9:0]  rem_q6k;  // (word / 10^6) mod 10^3
    logic [9:0]  rem_q4k;  // (word / 10^4) mod 10^3
    logic [3:0]  dig6;     // digit 10^6
    logic [3:0]  dig7;     // digit 10^7
    logic [3:0]  dig8;     // digit 10^8

    // Remainders from neighboring quotients, kept to their low bits
    assign rem_w4  = quot.word[13:0] - 14'(quot.q4[13:0] * 14'd10000);
    assign rem_q4  = quot.q4[13:0] - 14'({8'd0, quot.q8} * 14'd10000);
    assign rem_w3  = quot.word[9:0] - 10'(quot.q3[9:0] * 10'd1000);
    assign rem_q3  = quot.q3[9:0] - 10'(quot.q6[9:0] * 10'd1000);
    assign rem_q6k = quot.q6[9:0] - 10'({7'd0, quot.q9} * 10'd1000);
    assign rem_q4k = quot.q4[9:0] - 10'({1'b0, quot.q7} * 10'd1000);
    assign dig6    = quot.q6[3:0] - 4'(quot.q7[3:0] * 4'd10);
    assign dig7    = quot.q7[3:0] - 4'(quot.q8[3:0] * 4'd10);
    assign dig8    = quot.q8[3:0] - 4'({1'b0, quot.q9} * 4'd10);

    // Observation slot for field-number and residual words
    always_comb
    begin
        if (quot.pos >= cdu_pkg::POS_RES_FIRST)
        begin
            obs_idx = 3'(quot.pos - cdu_pkg::POS_RES_FIRST);
        end
        else
        begin
            obs_idx = 3'(quot.pos - cdu_pkg::POS_OBS_FIRST);
        end
    end

    assign fld_rd = fld_mem[obs_idx];

    // Decode by word position
    always_comb
    begin
        res_next      = '0;
        res_next.pos  = quot.pos;
        res_next.last = (quot.pos == cdu_pkg::POS_LAST);
        det_next      = det_reg;
        fld_we        = 1'b0;
        priority if (quot.pos == cdu_pkg::POS_RA)
        begin
            res_next.a   = $signed({1'b0, quot.word});
            res_next.err = (quot.word > cdu_pkg::RA_MAX);
        end
        else if (quot.pos == cdu_pkg::POS_SPD)
        begin
            res_next.a   = $signed({1'b0, quot.word}) - cdu_pkg::DEC_OFFSET;
            res_next.err = (quot.word > cdu_pkg::SPD_MAX);
        end
        else if (quot.pos == cdu_pkg::POS_MOTION)
        begin
            res_next.a   = $signed({19'd0, rem_w4}) - cdu_pkg::PM_OFFSET_A;
            res_next.b   = $signed({1'b0, rem_q4}) - cdu_pkg::PM_OFFSET_B;
            res_next.c   = {6'd0, dig8};
            res_next.d   = {4'd0, quot.q9};
            res_next.err = (quot.q9 > 3'd1);
        end
        else if (quot.pos == cdu_pkg::POS_PHOT)
        begin
            res_next.a   = $signed({23'd0, rem_w3});
            res_next.b   = $signed({5'd0, rem_q3});
            res_next.c   = {6'd0, dig6};
            res_next.d   = {3'd0, dig7};
            res_next.e   = dig8;
            res_next.f   = {1'b0, quot.q9};
            res_next.err = (quot.q9 > 3'd1);
            det_next     = dig8;
        end
        else if (quot.pos == cdu_pkg::POS_SIGMA)
        begin
            res_next.a   = $signed({23'd0, rem_w3});
            res_next.b   = $signed({5'd0, rem_q3});
            res_next.c   = rem_q6k;
            res_next.d   = {6'd0, (quot.q9 == 3'd1)};
            res_next.err = (det_reg != 4'd0) && (quot.q9 > 3'd1);
        end
        else if (quot.pos < cdu_pkg::POS_RES_FIRST)
        begin
            res_next.a   = $signed({19'd0, rem_w4});
            res_next.b   = $signed({5'd0, rem_q4k});
            res_next.c   = {6'd0, dig7};
            res_next.d   = {1'b0, quot.q8};
            res_next.err = (det_reg >= 4'd2) && (rem_q4k > cdu_pkg::FIELD_MAX);
            fld_we       = 1'b1;
        end
        else if (quot.pos < cdu_pkg::POS_SCN_FIRST)
        begin
            res_next.c = {6'd0, dig8};
            // Zero residuals of an empty observation
            if (!((det_reg >= 4'd2) && (fld_rd == '0)))
            begin
                res_next.a = $signed({19'd0, rem_w4}) - cdu_pkg::PM_OFFSET_A;
                res_next.b = $signed({1'b0, rem_q4}) - cdu_pkg::PM_OFFSET_B;
            end
        end
        else
        begin
            res_next.a   = $signed({1'b0, quot.word});
            res_next.err = (quot.word > cdu_pkg::SCAN_MAX);
        end
    end

    // Hold detection count across the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_reg <= '0;
        end
        else if (take)
        begin
            det_reg <= det_next;
        end
    end

    // Store field numbers for the residual words
    always_ff @(posedge clk)
    begin
        if (take && fld_we)
        begin
            fld_mem[obs_idx] <= rem_q4k;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    // Detection count only ever holds a decimal digit
    a_det_digit: assert property (@(posedge clk) disable iff (!rst_n)
        det_reg <= 4'd9)
        else $error("detection count out of digit range");

    // A photometry word that moves on loads its detection digit
    a_det_load: assert property (@(posedge clk) disable iff (!rst_n)
        (take && quot.pos == cdu_pkg::POS_PHOT) |=> (det_reg == $past(dig8)))
        else $error("detection count not loaded");

    // Detection count moves only on a photometry word
    a_det_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && quot.pos == cdu_pkg::POS_PHOT) |=> $stable(det_reg))
        else $error("detection count changed off its word");

endmodule

FILE: hdl/catalog_record_decimal_unpacker_unit.sv
// Top level of the catalog record decimal unpacker: handshake, word counter, pipeline.
//
//  channel | dir | payload
//  --------+-----+-----------------------------------------------------------
//  s_*     | in  | tdata[31:0] record_word
//  m_*     | out | tdata: word_position, value_a..value_f; tuser: range_error;
//          |     | tlast: record_last
//
//  One word per cycle unless the output stalls; each word passes the input register,
//  the quotient register from the reciprocal multipliers and the result register.
//  Reset clears the word counter, detection count and all stage valids;
//  the first word after reset is word 0 of a record.
//  A stalled output holds every stage; s_tready follows the output slot.
module catalog_record_decimal_unpacker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] record_word
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] word_position, [37:5] value_a, [52:38] value_b, [62:53] value_c,
    // [69:63] value_d, [73:70] value_e, [77:74] value_f, [79:78] zero
    output logic [cdu_pkg::TDATA_W-1:0] m_tdata,
    output logic        m_tuser,   // [0] range_error
    output logic        m_tlast
);

    logic                          en;
    logic                          s_accept;
    logic [cdu_pkg::POS_W-1:0]     cnt_reg;
    logic [cdu_pkg::POS_W-1:0]     cnt_next;
    logic                          in_vld_reg;
    logic                          quot_vld_reg;
    logic                          out_vld_reg;
    logic [cdu_pkg::WORD_W-1:0]    word_reg;
    logic [cdu_pkg::POS_W-1:0]     pos_reg;
    cdu_pkg::cdu_quot_t            quot_reg;
    cdu_pkg::cdu_result_t          res_reg;

    // Advance the whole pipeline unless the output slot is full and stalled
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign s_accept = s_tvalid && en;
    assign cnt_next = (cnt_reg == cdu_pkg::POS_LAST) ? '0 : cnt_reg + 5'd1;

    // Word counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (s_accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            quot_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            in_vld_reg   <= s_tvalid;
            quot_vld_reg <= in_vld_reg;
            out_vld_reg  <= quot_vld_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= s_tdata;
            pos_reg  <= cnt_reg;
        end
    end

    cdu_divide u_divide
    (
        .clk      (clk),
        .en       (en),
        .word     (word_reg),
        .pos      (pos_reg),
        .quot_reg (quot_reg)
    );

    cdu_fields u_fields
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .take    (en && quot_vld_reg),
        .quot    (quot_reg),
        .res_reg (res_reg)
    );

    // Pack the output word
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, res_reg.f, res_reg.e, res_reg.d, res_reg.c,
                       res_reg.b, res_reg.a, res_reg.pos};
    assign m_tuser  = res_reg.err;
    assign m_tlast  = res_reg.last;

    // Counter stays inside one record
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cdu_pkg::POS_LAST)
        else $error("word counter beyond record length");

    // Last word of a record wraps the counter
    a_cnt_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && cnt_reg == cdu_pkg::POS_LAST) |=> (cnt_reg == '0))
        else $error("word counter did not wrap");

    // Record end flag matches the position it carries
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (res_reg.pos == cdu_pkg::POS_LAST)))
        else $error("record_last disagrees with word_position");

    // A held result keeps the input side stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

FILE: dv/tb_catalog_record_decimal_unpacker_unit.sv
`timescale 1ns / 1ps
// Testbench for the catalog record decimal unpacker: record word streams checked by a scoreboard.
module tb_catalog_record_decimal_unpacker_unit;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [31:0]                 s_tdata;    // [31:0] record_word
    logic                        m_tvalid;
    logic                        m_tready;
    // [4:0] word_position, [37:5] value_a, [52:38] value_b, [62:53] value_c,
    // [69:63] value_d, [73:70] value_e, [77:74] value_f, [79:78] zero
    logic [cdu_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tuser;    // [0] range_error
    logic                        m_tlast;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Scoreboard: predicts the unpacked word for each accepted record word
    class unpack_scoreboard;
        cdu_pkg::cdu_result_t      pending_results[$];
        logic [cdu_pkg::POS_W-1:0] word_index;
        logic [cdu_pkg::E_W-1:0]   det_count;
        logic [cdu_pkg::FLD_W-1:0] field_store [cdu_pkg::OBS_N];
        int                        mismatches;

        function new();
            word_index = '0;
            det_count  = '0;
            foreach (field_store[i])
            begin
                field_store[i] = '0;
            end
            mismatches = 0;
        endfunction

        // Count a failure; show the first ten in detail
        function void flag(string what, logic [4:0] pos, longint unsigned want,
                           longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch at %0t: word %0d %s expected 0x%0h got 0x%0h",
                         $realtime, pos, what, want, got);
            end
        endfunction

        // Split one record word into its digit groups and queue the result
        function void note_word(logic [cdu_pkg::WORD_W-1:0] w);
            longint unsigned      wv;
            longint               av;
            longint               bv;
            int unsigned          cv;
            int unsigned          dv;
            int unsigned          ev;
            int unsigned          fv;
            int unsigned          k;
            int unsigned          fld;
            int unsigned          m;
            int                   obs;
            bit                   err;
            cdu_pkg::cdu_result_t r;

            wv  = 64'(w);
            av  = 0;
            bv  = 0;
            cv  = 0;
            dv  = 0;
            ev  = 0;
            fv  = 0;
            err = 1'b0;
            m   = 32'(det_count);

            if (word_index == cdu_pkg::POS_RA)
            begin
                av  = wv;
                err = (w > cdu_pkg::RA_MAX);
            end
            else if (word_index == cdu_pkg::POS_SPD)
            begin
                av  = longint'(wv) - longint'(cdu_pkg::DEC_OFFSET);
                err = (w > cdu_pkg::SPD_MAX);
            end
            else if (word_index == cdu_pkg::POS_MOTION)
            begin
                av  = longint'(wv % 10000) - longint'(cdu_pkg::PM_OFFSET_A);
                bv  = longint'((wv / 10000) % 10000) - longint'(cdu_pkg::PM_OFFSET_A);
                cv  = 32'((wv / 100000000) % 10);
                dv  = 32'((wv / 1000000000) % 10);
                err = (dv > 1);
            end
            else if (word_index == cdu_pkg::POS_PHOT)
            begin
                av  = wv % 1000;
                bv  = (wv / 1000) % 1000;
                cv  = 32'((wv / 1000000) % 10);
                dv  = 32'((wv / 10000000) % 10);
                ev  = 32'((wv / 100000000) % 10);
                fv  = 32'((wv / 1000000000) % 10);
                det_count = ev[cdu_pkg::E_W-1:0];
                err = (fv > 1);
            end
            else if (word_index == cdu_pkg::POS_SIGMA)
            begin
                k   = 32'((wv / 1000000000) % 10);
                av  = wv % 1000;
                bv  = (wv / 1000) % 1000;
                cv  = 32'((wv / 1000000) % 1000);
                dv  = (k == 1) ? 1 : 0;
                err = (m != 0) && (k > 1);
            end
            else if (word_index < cdu_pkg::POS_RES_FIRST)
            begin
                obs = int'(word_index - cdu_pkg::POS_OBS_FIRST);
                fld = 32'((wv / 10000) % 1000);
                av  = wv % 10000;
                bv  = longint'(fld);
                cv  = 32'((wv / 10000000) % 10);
                dv  = 32'((wv / 100000000) % 100);
                field_store[obs] = fld[cdu_pkg::FLD_W-1:0];
                err = (m >= 2) && (fld > cdu_pkg::FIELD_MAX);
            end
            else if (word_index < cdu_pkg::POS_SCN_FIRST)
            begin
                obs = int'(word_index - cdu_pkg::POS_RES_FIRST);
                cv  = 32'((wv / 100000000) % 10);
                // Zero the residuals of an empty observation
                if (!(m >= 2 && field_store[obs] == '0))
                begin
                    av = longint'(wv % 10000) - longint'(cdu_pkg::PM_OFFSET_A);
                    bv = longint'((wv / 10000) % 10000) - longint'(cdu_pkg::PM_OFFSET_A);
                end
            end
            else
            begin
                av  = wv;
                err = (w > cdu_pkg::SCAN_MAX);
            end

            r.pos  = word_index;
            r.a    = av[cdu_pkg::A_W-1:0];
            r.b    = bv[cdu_pkg::B_W-1:0];
            r.c    = cv[cdu_pkg::C_W-1:0];
            r.d    = dv[cdu_pkg::D_W-1:0];
            r.e    = ev[cdu_pkg::E_W-1:0];
            r.f    = fv[cdu_pkg::F_W-1:0];
            r.err  = err;
            r.last = (word_index == cdu_pkg::POS_LAST);
            pending_results.push_back(r);

            word_index = (word_index == cdu_pkg::POS_LAST) ? '0 : word_index + 1'b1;
        endfunction

        // Compare one output word with the oldest prediction
        function void check_result(logic [cdu_pkg::TDATA_W-1:0] tdata, logic tuser,
                                   logic tlast);
            cdu_pkg::cdu_result_t want;

            if (pending_results.size() == 0)
            begin
                flag("unexpected word, tdata", tdata[4:0], 0, tdata[63:0]);
                return;
            end
            want = pending_results.pop_front();
            if (tdata[4:0] != want.pos)
                flag("word_position", want.pos, want.pos, tdata[4:0]);
            if (tdata[37:5] != want.a)
                flag("value_a", want.pos, $unsigned(want.a), tdata[37:5]);
            if (tdata[52:38] != want.b)
                flag("value_b", want.pos, $unsigned(want.b), tdata[52:38]);
            if (tdata[62:53] != want.c)
                flag("value_c", want.pos, want.c, tdata[62:53]);
            if (tdata[69:63] != want.d)
                flag("value_d", want.pos, want.d, tdata[69:63]);
            if (tdata[73:70] != want.e)
                flag("value_e", want.pos, want.e, tdata[73:70]);
            if (tdata[77:74] != want.f)
                flag("value_f", want.pos, want.f, tdata[77:74]);
            if (tdata[79:78] != 2'b00)
                flag("pad bits", want.pos, 0, tdata[79:78]);
            if (tuser !== want.err)
                flag("range_error", want.pos, want.err, tuser);
            if (tlast !== want.last)
                flag("record_last", want.pos, want.last, tlast);
        endfunction
    endclass

    unpack_scoreboard sb = new();

    // Edge values: range limits, oversized leading digits, empty observation
    logic [31:0] directed_words [20] = '{
        32'd129600001, 32'd64800000, 32'hFFFFFFFF, 32'd1299999000, 32'hFFFFFFFF,
        32'd4190009999, 32'd9380000, 32'd9379999, 32'd0, 32'hFFFFFFFF,
        32'd999999999, 32'd0, 32'hFFFFFFFF, 32'd950005000, 32'd123456789,
        32'd9999999, 32'd10000000, 32'd0, 32'hFFFFFFFF, 32'd129600000
    };

    catalog_record_decimal_unpacker_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Build a mostly well-formed word for a record position
    function automatic logic [31:0] build_word(int unsigned pos);
        longint unsigned v;
        int unsigned     pick;

        pick = $urandom_range(0, 99);
        if (pick < 12)
            return $urandom;
        if (pos == 0)
            v = (pick < 18) ? cdu_pkg::RA_MAX + $urandom_range(0, 1)
                            : $urandom_range(0, cdu_pkg::RA_MAX);
        else if (pos == 1)
            v = (pick < 18) ? cdu_pkg::SPD_MAX + $urandom_range(0, 1)
                            : $urandom_range(0, cdu_pkg::SPD_MAX);
        else if (pos == 2)
            v = longint'($urandom_range(0, 1)) * 1000000000 + $urandom_range(0, 9) * 100000000
                + $urandom_range(0, 9999) * 10000 + $urandom_range(0, 9999);
        else if (pos == 3)
            v = longint'($urandom_range(0, 1)) * 1000000000 + $urandom_range(0, 9) * 100000000
                + $urandom_range(0, 9) * 10000000 + $urandom_range(0, 9) * 1000000
                + $urandom_range(0, 999) * 1000 + $urandom_range(0, 999);
        else if (pos == 4)
            v = longint'($urandom_range(0, 1)) * 1000000000 + $urandom_range(0, 999) * 1000000
                + $urandom_range(0, 999) * 1000 + $urandom_range(0, 999);
        else if (pos < 10)
            v = longint'($urandom_range(0, 41)) * 100000000 + $urandom_range(0, 9) * 10000000
                + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 999)) * 10000
                + $urandom_range(0, 9999);
        else if (pos < 15)
            v = longint'($urandom_range(0, 9)) * 100000000 + $urandom_range(0, 9999) * 10000
                + $urandom_range(0, 9999);
        else
            v = (pick < 18) ? cdu_pkg::SCAN_MAX + $urandom_range(0, 1)
                            : $urandom_range(0, cdu_pkg::SCAN_MAX);
        return v[31:0];
    endfunction

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_word(logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Receiver stalls
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watch both handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int drain;

        send_idle_pct = 16;
        recv_idle_pct = 86;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
            send_word(directed_words[i]);

        for (int rec = 0; rec < 27; rec++)
        begin
            if (rec == 9)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 16;
            end
            else if (rec == 18)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int p = 0; p < 20; p++)
                send_word(build_word(p));
        end
        s_tvalid <= 1'b0;

        // Drain the pending predictions, then let the pipeline settle
        drain = 0;
        while (sb.pending_results.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.flag("words never produced, count", 5'd0, 0, sb.pending_results.size());

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
